FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the base64url stream codec.
// Each macro is a labeled concurrent assertion clocked on the given clock,
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

FILE: sv/b64u_pkg.sv
// Package for the base64url stream codec: direction codes, bit position
// constants, alphabet characters and the character mapping functions.
// Depends on nothing; base64url_stream_codec.sv uses it.
package b64u_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Bit position counter values (signed, four bits).
    localparam logic signed [3:0] PEND_M2 = -4'sd2;
    localparam logic signed [3:0] PEND_M4 = -4'sd4;
    localparam logic signed [3:0] PEND_M6 = -4'sd6;
    localparam logic signed [3:0] PEND_M8 = -4'sd8;

    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_DASH      = 8'h2D;
    localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;

    localparam logic [5:0] SEXTET_DASH      = 6'd62;
    localparam logic [5:0] SEXTET_UNDERLINE = 6'd63;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // Maps a six-bit value to its URL-safe alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] ext;
        ext = {2'b00, v};
        if (v < 6'd26) begin
            return 8'(ext + CHAR_UPPER_A);
        end else if (v < 6'd52) begin
            return 8'(ext + CHAR_LOWER_A - 8'd26);
        end else if (v < SEXTET_DASH) begin
            return 8'(ext + CHAR_DIGIT_0 - 8'd52);
        end else if (v == SEXTET_DASH) begin
            return CHAR_DASH;
        end else begin
            return CHAR_UNDERLINE;
        end
    endfunction

    // Maps an ASCII character to its six-bit value; ok is low outside the alphabet.
    function automatic t_sextet char_value(input logic [7:0] c);
        t_sextet r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r.val = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r.val = 6'(c - CHAR_LOWER_A + 8'd26);
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r.val = 6'(c - CHAR_DIGIT_0 + 8'd52);
        end else if (c == CHAR_DASH) begin
            r.val = SEXTET_DASH;
        end else if (c == CHAR_UNDERLINE) begin
            r.val = SEXTET_UNDERLINE;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/b64u_if.sv
// Valid/ready channel interfaces of the base64url stream codec: input
// items, result items and the direction register write channel.
// No dependencies.
interface b64u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface b64u_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

FILE: sv/base64url_stream_codec.sv
// Streaming unpadded base64url encoder/decoder with a direction register.
// Depends on b64u_pkg, the channel interfaces in b64u_if.sv and assert_macros.svh.
//
// Usage: i_cfg writes the direction (0 encode, 1 decode); it is ready whenever
// reset is released, and every write restarts the message state for the chosen
// direction, so write it only while no request is in flight. i_in carries one
// byte or character per request with end_of_message on the final one of a message.
// o_out delivers the result requests, run_last set on the last result that
// a given input caused.
// An accepted input is held in the input register and is then turned, in a
// single pass, into zero, one or two results held in a two-entry result
// register, whose head entry is offered on o_out. The result register
// drains one result per cycle while o_out is ready; the input register can
// take the next item meanwhile, and it is processed once the result register
// holds no result that stays. An encoded byte yields one or two characters,
// a decoded character zero or one byte.
// Reset clears the pipeline, holds both input channels not ready and selects
// encode with an empty message.
// When the receiver stalls, the results hold on o_out, the input register
// keeps the next item and i_in drops ready until room opens up again.
module base64url_stream_codec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64u_cfg_if.sink          i_cfg,
    b64u_in_if.sink           i_in,
    b64u_out_if.source        o_out
);

    // Message state.
    logic                    r_dir;
    logic [13:0]             r_acc;
    logic signed [3:0]       r_pend;
    logic                    r_stop;
    logic [13:0]             n_acc;
    logic signed [3:0]       n_pend;
    logic                    n_stop;

    // Input register.
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_eom;

    // Two-entry result register; entry 0 is the head shown on o_out.
    logic [1:0]              r_cnt;
    logic [7:0]              r_res_byte [2];
    logic                    r_res_last [2];
    logic [1:0]              n_cnt;
    logic [7:0]              n_res_byte [2];
    logic                    n_res_last [2];

    // Results of the single processing pass.
    logic [1:0]              res_n;
    logic [7:0]              res_a;
    logic [7:0]              res_b;
    logic [13:0]             acc_enc;
    logic [13:0]             acc_dec;
    b64u_pkg::t_sextet       dec;

    logic                    in_accept;
    logic                    pop;
    logic                    can_load;
    logic                    fire;
    logic                    enc_pend_ok;
    logic                    enc_fire;

    assign pop       = (r_cnt != 2'd0) && o_out.ready;
    // The buffer can take a new pair only if it is empty after this cycle.
    assign can_load  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign fire      = r_in_valid && can_load;
    assign i_in.ready = i_rst_n && (!r_in_valid || fire);
    assign in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_res_byte[0];
    assign o_out.run_last = r_res_last[0];

    // One processing pass: the new bits join the accumulator and every
    // complete character or byte is picked out at a position fixed by the
    // bit position counter.
    always_comb begin
        acc_enc = {r_acc[5:0], r_in_byte};
        dec     = b64u_pkg::char_value(r_in_byte);
        acc_dec = {r_acc[7:0], dec.val};
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_stop  = r_stop;
        res_n   = 2'd0;
        res_a   = 8'd0;
        res_b   = 8'd0;
        if (r_dir == b64u_pkg::DIR_ENCODE) begin
            n_acc = acc_enc;
            case (r_pend)
                b64u_pkg::PEND_M6: begin
                    // Two bits stay behind; a final byte flushes them zero-filled.
                    res_a  = b64u_pkg::enc_char(acc_enc[7:2]);
                    res_b  = b64u_pkg::enc_char({acc_enc[1:0], 4'b0000});
                    res_n  = r_in_eom ? 2'd2 : 2'd1;
                    n_pend = b64u_pkg::PEND_M4;
                end
                b64u_pkg::PEND_M4: begin
                    res_a  = b64u_pkg::enc_char(acc_enc[9:4]);
                    res_b  = b64u_pkg::enc_char({acc_enc[3:0], 2'b00});
                    res_n  = r_in_eom ? 2'd2 : 2'd1;
                    n_pend = b64u_pkg::PEND_M2;
                end
                default: begin
                    // Third byte of a group completes two characters.
                    res_a  = b64u_pkg::enc_char(acc_enc[11:6]);
                    res_b  = b64u_pkg::enc_char(acc_enc[5:0]);
                    res_n  = 2'd2;
                    n_pend = b64u_pkg::PEND_M6;
                end
            endcase
        end else if (!r_stop) begin
            if (!dec.ok) begin
                n_stop = 1'b1;
            end else begin
                n_acc = acc_dec;
                case (r_pend)
                    b64u_pkg::PEND_M8: begin
                        n_pend = b64u_pkg::PEND_M2;
                    end
                    b64u_pkg::PEND_M2: begin
                        res_a  = acc_dec[11:4];
                        res_n  = 2'd1;
                        n_pend = b64u_pkg::PEND_M4;
                    end
                    b64u_pkg::PEND_M4: begin
                        res_a  = acc_dec[9:2];
                        res_n  = 2'd1;
                        n_pend = b64u_pkg::PEND_M6;
                    end
                    default: begin
                        res_a  = acc_dec[7:0];
                        res_n  = 2'd1;
                        n_pend = b64u_pkg::PEND_M8;
                    end
                endcase
            end
        end
        if (r_in_eom) begin
            n_acc  = 14'd0;
            n_pend = (r_dir == b64u_pkg::DIR_DECODE) ?
                     b64u_pkg::PEND_M8 : b64u_pkg::PEND_M6;
            n_stop = 1'b0;
        end
    end

    // Result register: a load replaces the contents, a pop shifts them down.
    always_comb begin
        n_cnt         = r_cnt;
        n_res_byte[0] = r_res_byte[0];
        n_res_byte[1] = r_res_byte[1];
        n_res_last[0] = r_res_last[0];
        n_res_last[1] = r_res_last[1];
        if (fire) begin
            n_cnt         = res_n;
            n_res_byte[0] = res_a;
            n_res_byte[1] = res_b;
            n_res_last[0] = (res_n == 2'd1);
            n_res_last[1] = 1'b1;
        end else if (pop) begin
            n_cnt         = r_cnt - 2'd1;
            n_res_byte[0] = r_res_byte[1];
            n_res_last[0] = r_res_last[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= b64u_pkg::DIR_ENCODE;
            r_acc      <= 14'd0;
            r_pend     <= b64u_pkg::PEND_M6;
            r_stop     <= 1'b0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg.valid) begin
                r_dir  <= i_cfg.direction;
                r_acc  <= 14'd0;
                r_pend <= (i_cfg.direction == b64u_pkg::DIR_DECODE) ?
                          b64u_pkg::PEND_M8 : b64u_pkg::PEND_M6;
                r_stop <= 1'b0;
            end else if (fire) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_stop <= n_stop;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_eom  <= i_in.end_of_message;
        end
        r_res_byte[0] <= n_res_byte[0];
        r_res_byte[1] <= n_res_byte[1];
        r_res_last[0] <= n_res_last[0];
        r_res_last[1] <= n_res_last[1];
    end

    // Helper terms for the checks below.
    assign enc_pend_ok = (r_pend == b64u_pkg::PEND_M6) || (r_pend == b64u_pkg::PEND_M4) ||
                         (r_pend == b64u_pkg::PEND_M2);
    assign enc_fire    = fire && (r_dir == b64u_pkg::DIR_ENCODE) && !i_cfg.valid;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
    `ASSERT_IMPLY(a_head_of_pair_not_last, i_clk, i_rst_n, r_cnt == 2'd2, !r_res_last[0])
    `ASSERT_IMPLY(a_enc_pend_legal, i_clk, i_rst_n, r_dir == b64u_pkg::DIR_ENCODE, enc_pend_ok)
    `ASSERT_NEXT(a_enc_yields_result, i_clk, i_rst_n, enc_fire, r_cnt != 2'd0)

endmodule
